FILE: src/ttsd_pkg.sv
// Shared types, constants and helpers for the trigram tokeniser unit.
package ttsd_pkg;

    localparam int MAX_LEN_DEF = 32;
    localparam int BASE_DEF    = 28;

    localparam int CHR_W   = 8;
    localparam int SYM_W   = 5;
    localparam int CODE_W  = 15;
    localparam int UCNT_W  = 6;

    localparam logic [CHR_W-1:0] CHR_LOWER_A = 8'h61;
    localparam logic [CHR_W-1:0] CHR_LOWER_Z = 8'h7a;
    localparam logic [SYM_W-1:0] SYM_PAD     = '0;

    typedef struct packed {
        logic [CHR_W-1:0] chr;
        logic             chr_valid;
        logic             end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] trigram_code;
        logic [UCNT_W-1:0] unique_count;
        logic              truncated;
        logic              last_of_run;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_char;  // a character transaction was accepted
        logic close;      // insert the closing window (trailing pad)
        logic load_out;   // move the lowest code into the output register
        logic clear;      // return all string state to reset values
    } ttsd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit_last;  // the code about to be emitted is the final one
    } ttsd_status_t;

    // Letters a to z map to 1 to 26; every other byte maps to the pad symbol.
    function automatic logic [SYM_W-1:0] symbol_of(input logic [CHR_W-1:0] c);
        logic [CHR_W-1:0] diff;
        diff = c - CHR_LOWER_A + 8'd1;
        if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z)
            return diff[SYM_W-1:0];
        return SYM_PAD;
    endfunction

endpackage

FILE: src/trigram_tokeniser_sort_dedupe_unit.sv
// Top level of the trigram tokeniser with sorted, duplicate-free code store.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_ready  | in_item: chr, chr_valid, end_of_string
//  output  | out_valid / out_ready| out_item: trigram_code, unique_count,
//          |                      |           truncated, last_of_run
//
// A character transaction has its window coded and inserted into the
// register-chain sorter in the cycle it is accepted, up to MAX_LEN characters.
// An end-of-string transaction is followed by the closing window (ST_CLOSE),
// then by the burst of unique codes, one code per cycle while the output side
// does not stall; input is refused from the end mark to the last code.
// Reset clears all control state; the code chain itself needs no clearing.
// An output stall holds the output register and pauses the burst.
module trigram_tokeniser_sort_dedupe_unit #(
    parameter int MAX_LEN = ttsd_pkg::MAX_LEN_DEF,
    parameter int BASE    = ttsd_pkg::BASE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ttsd_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output ttsd_pkg::out_item_t out_item
);
    import ttsd_pkg::*;

    ttsd_cmd_t    cmd;
    ttsd_status_t status;

    ttsd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_chr_valid (in_item.chr_valid),
        .in_end       (in_item.end_of_string),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cmd          (cmd),
        .status       (status)
    );

    ttsd_datapath #(
        .MAX_LEN (MAX_LEN),
        .BASE    (BASE)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cmd      (cmd),
        .status   (status),
        .out_item (out_item)
    );

endmodule

FILE: src/ttsd_ctrl.sv
// Controller state machine: sequences input, closing window and result burst.
module ttsd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_chr_valid,
    input  logic                  in_end,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ttsd_pkg::ttsd_cmd_t    cmd,
    input  ttsd_pkg::ttsd_status_t status
);
    import ttsd_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLOSE = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       in_fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.take_char = in_fire && in_chr_valid;
                if (in_fire && in_end)
                    state_next = ST_CLOSE;
            end
            ST_CLOSE:
            begin
                cmd.close  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // The output register is free, or is being emptied this cycle.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.emit_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: src/ttsd_datapath.sv
// Datapath: window coder, sorted register-chain store and output register.
module ttsd_datapath #(
    parameter int MAX_LEN = ttsd_pkg::MAX_LEN_DEF,
    parameter int BASE    = ttsd_pkg::BASE_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ttsd_pkg::in_item_t      in_item,
    input  ttsd_pkg::ttsd_cmd_t     cmd,
    output ttsd_pkg::ttsd_status_t  status,
    output ttsd_pkg::out_item_t     out_item
);
    import ttsd_pkg::*;

    localparam int DEPTH   = MAX_LEN + 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CHCNT_W = $clog2(MAX_LEN + 1);
    localparam logic [CODE_W-1:0] MUL1 = CODE_W'(BASE);
    localparam logic [CODE_W-1:0] MUL2 = CODE_W'(BASE * BASE);

    logic [CODE_W-1:0]  cell_reg [DEPTH];
    logic [CODE_W-1:0]  cell_next[DEPTH];
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CHCNT_W-1:0] char_cnt_reg, char_cnt_next;
    logic               ovf_reg, ovf_next;
    logic [SYM_W-1:0]   older_reg, older_next;
    logic [SYM_W-1:0]   newer_reg, newer_next;
    out_item_t          out_reg, out_next;

    logic               chars_full;
    logic               do_insert;
    logic [SYM_W-1:0]   new_sym;
    logic [CODE_W-1:0]  code;
    logic [DEPTH-1:0]   lt_vec;
    logic [DEPTH-1:0]   eq_vec;
    logic               dup;

    assign chars_full = (char_cnt_reg == CHCNT_W'(MAX_LEN));
    assign do_insert  = cmd.close || (cmd.take_char && !chars_full);
    assign new_sym    = cmd.close ? SYM_PAD : symbol_of(in_item.chr);
    assign code       = CODE_W'(older_reg) + CODE_W'(newer_reg) * MUL1
                        + CODE_W'(new_sym) * MUL2;

    // Each occupied cell compares itself with the new code. As the chain is
    // sorted, the less-than flags form a thermometer ending at the insert slot.
    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            lt_vec[k] = (CNT_W'(k) < count_reg) && (cell_reg[k] < code);
            eq_vec[k] = (CNT_W'(k) < count_reg) && (cell_reg[k] == code);
        end
    end
    assign dup = |eq_vec;

    assign status.emit_last = (idx_reg == count_reg - CNT_W'(1));

    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
            cell_next[k] = cell_reg[k];
        count_next    = count_reg;
        idx_next      = idx_reg;
        char_cnt_next = char_cnt_reg;
        ovf_next      = ovf_reg;
        older_next    = older_reg;
        newer_next    = newer_reg;
        out_next      = out_reg;

        if (cmd.take_char)
        begin
            if (chars_full)
                ovf_next = 1'b1;
            else
                char_cnt_next = char_cnt_reg + CHCNT_W'(1);
        end

        if (do_insert)
        begin
            older_next = newer_reg;
            newer_next = new_sym;
            if (!dup)
            begin
                count_next = count_reg + CNT_W'(1);
                for (int k = 0; k < DEPTH; k++)
                begin
                    if (!lt_vec[k])
                    begin
                        if (k == 0)
                            cell_next[k] = code;
                        else if (lt_vec[k-1])
                            cell_next[k] = code;
                        else
                            cell_next[k] = cell_reg[k-1];
                    end
                end
            end
        end

        if (cmd.load_out)
        begin
            out_next.trigram_code = cell_reg[0];
            out_next.unique_count = UCNT_W'(count_reg);
            out_next.truncated    = ovf_reg;
            out_next.last_of_run  = status.emit_last;
            idx_next              = idx_reg + CNT_W'(1);
            for (int k = 0; k < DEPTH - 1; k++)
                cell_next[k] = cell_reg[k+1];
        end

        if (cmd.clear)
        begin
            count_next    = '0;
            idx_next      = '0;
            char_cnt_next = '0;
            ovf_next      = 1'b0;
            older_next    = SYM_PAD;
            newer_next    = SYM_PAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            idx_reg      <= '0;
            char_cnt_reg <= '0;
            ovf_reg      <= 1'b0;
            older_reg    <= SYM_PAD;
            newer_reg    <= SYM_PAD;
        end
        else
        begin
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            char_cnt_reg <= char_cnt_next;
            ovf_reg      <= ovf_next;
            older_reg    <= older_next;
            newer_reg    <= newer_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DEPTH; k++)
            cell_reg[k] <= cell_next[k];
        out_reg <= out_next;
    end

    assign out_item = out_reg;

endmodule
